[rtl/core/bsgm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsgm_pkg
// Shared constants, types and floating-point helpers of the gap marker.
// ----------------------------------------------------------------------------
package bsgm_pkg;

	localparam int NUM_INTERVALS_DEF = 2;
	localparam int BOUND_REGS = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ICNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAXRUN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER1 = 3'd7;

	localparam logic [5:0] MODE_RESET = 6'd13;

	typedef struct packed {
		logic [63:0] sample_bits;
		logic buffer_gap;
		logic buffer_discont;
		logic buffer_first;
	} bsgm_in_t;

	typedef struct packed {
		logic [63:0] out_sample;
		logic gap_flag;
		logic segment_start;
		logic discont_flag;
	} bsgm_out_t;

	typedef struct packed {
		logic [5:0] mode;
		logic [63:0] repl;
		logic [1:0] icnt;
		logic [31:0] max_run;
	} bsgm_cfg_t;

	// Widens a single-precision pattern to the exact double pattern.
	function automatic logic [63:0] f2d(input logic [31:0] f);
		logic [7:0] e;
		logic [22:0] m;
		logic [63:0] r;
		int sh;
		e = f[30:23];
		m = f[22:0];
		r = {f[31], 63'd0};
		sh = 0;
		if (e == 8'hFF) begin
			r[62:52] = 11'h7FF;
			r[51:29] = m;
		end else if (e != 8'd0) begin
			r[62:52] = 11'(e) + 11'd896;
			r[51:29] = m;
		end else if (m != 23'd0) begin
			for (int i = 22; i >= 0; i--) begin
				if (sh == 0 && m[i]) sh = 23 - i;
			end
			r[62:52] = 11'(897 - sh);
			r[51:29] = 23'(m << sh);
		end
		return r;
	endfunction

	// Rounds a double pattern to single precision, nearest even.
	function automatic logic [31:0] d2f(input logic [63:0] b);
		logic s;
		logic [62:0] mag;
		logic [10:0] e;
		logic [53:0] sig;
		logic [53:0] shv;
		logic [24:0] q;
		logic rb, st;
		int ex;
		int sa;
		logic [31:0] r;
		s = b[63];
		mag = b[62:0];
		e = b[62:52];
		sig = {1'b0, (e != 11'd0), b[51:0]};
		ex = int'(e) - 896;
		r = {s, 31'd0};
		shv = '0;
		q = '0;
		rb = 1'b0;
		st = 1'b0;
		sa = 0;
		if (mag > 63'h7FF0000000000000) begin
			r = {s, 8'hFF, 1'b1, mag[50:29]};
		end else if (mag >= 63'h47EFFFFFF0000000) begin
			r = {s, 8'hFF, 23'd0};
		end else if (ex >= 1) begin
			q = {1'b0, sig[52:29]};
			rb = sig[28];
			st = |sig[27:0];
			if (rb && (st || q[0])) q = q + 25'd1;
			r[30:0] = 31'({8'(ex - 1), 23'd0}) + 31'(q);
		end else begin
			sa = 1 - ex;
			if (sa > 30) sa = 30;
			shv = sig >> sa;
			st = |(sig & ((54'd1 << sa) - 54'd1));
			q = {1'b0, shv[52:29]};
			rb = shv[28];
			st = st | (|shv[27:0]);
			if (rb && (st || q[0])) q = q + 25'd1;
			r[30:0] = 31'(q);
		end
		return r;
	endfunction

	// Double comparison a <= b; false when either is NaN.
	function automatic logic fle(input logic [63:0] a, input logic [63:0] b);
		logic na, nb;
		logic r;
		na = a[62:52] == 11'h7FF && a[51:0] != 52'd0;
		nb = b[62:52] == 11'h7FF && b[51:0] != 52'd0;
		if (na || nb) r = 1'b0;
		else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) r = 1'b1;
		else if (a[63] != b[63]) r = a[63];
		else if (!a[63]) r = a[62:0] <= b[62:0];
		else r = a[62:0] >= b[62:0];
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/bsgm_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsgm_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface bsgm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/bsgm_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsgm_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module bsgm_cfg_regs
	import bsgm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output bsgm_cfg_t cfg,
	output logic [BOUND_REGS-1:0][63:0] lower,
	output logic [BOUND_REGS-1:0][63:0] upper
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode <= MODE_RESET;
			cfg.repl <= '0;
			cfg.icnt <= '0;
			cfg.max_run <= '1;
			lower <= '0;
			upper <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: cfg.mode <= cfg_data[5:0];
				REG_REPL: cfg.repl <= cfg_data;
				REG_ICNT: cfg.icnt <= cfg_data[1:0];
				REG_MAXRUN: cfg.max_run <= cfg_data[31:0];
				REG_LOWER0: lower[0] <= cfg_data;
				REG_UPPER0: upper[0] <= cfg_data;
				REG_LOWER1: lower[1] <= cfg_data;
				REG_UPPER1: upper[1] <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/bsgm_classify.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsgm_classify
// Decides whether a sample is bad and picks the output value.
// ----------------------------------------------------------------------------
module bsgm_classify
	import bsgm_pkg::*;
#(
	parameter int NUM_INTERVALS = NUM_INTERVALS_DEF
) (
	input wire bsgm_cfg_t cfg,
	input wire logic [BOUND_REGS-1:0][63:0] lower,
	input wire logic [BOUND_REGS-1:0][63:0] upper,
	input wire logic [63:0] repl_single,
	input wire logic [63:0] sample_bits,
	output logic bad,
	output logic [63:0] value
);
	localparam int LIMIT = NUM_INTERVALS < BOUND_REGS ? NUM_INTERVALS : BOUND_REGS;
	logic single;
	logic [63:0] sb;
	logic [63:0] x;
	logic is_nan, is_inf, hit;

	always_comb begin
		single = cfg.mode[5];
		sb = single ? {32'd0, sample_bits[31:0]} : sample_bits;
		x = single ? f2d(sample_bits[31:0]) : sample_bits;
		is_nan = x[62:52] == 11'h7FF && x[51:0] != 52'd0;
		is_inf = x[62:52] == 11'h7FF && x[51:0] == 52'd0;
		hit = 1'b0;
		for (int i = 0; i < LIMIT; i++) begin
			if (32'(cfg.icnt) > 32'(i) && fle(lower[i], x) && fle(x, upper[i]))
				hit = 1'b1;
		end
		bad = hit || (cfg.mode[2] && is_nan) || (cfg.mode[3] && is_inf);
		if (bad && cfg.mode[4]) value = single ? repl_single : cfg.repl;
		else value = sb;
	end
endmodule
`default_nettype wire

[rtl/core/bad_sample_gap_marker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bad_sample_gap_marker
// Marks, and optionally replaces, bad samples and opens output segments.
// ----------------------------------------------------------------------------
// Samples enter on in_ch and leave on out_ch, both valid/ready channels.
// A request on in_ch is registered in the input stage, classified by one
// stage of logic and written to the output register, which offers the
// result on out_ch. One sample is taken per cycle when out_ch is ready.
// The output register holds while the receiver stalls, and the input stage
// still takes a new request whenever the output register is empty or moves.
// The user must write registers through cfg_we/cfg_index/cfg_data while the
// block is idle (not enforced). A register holds cfg.repl in single precision.
// Reset empties both stages, clears the run counter and the previous gap
// flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module bad_sample_gap_marker
	import bsgm_pkg::*;
#(
	parameter int NUM_INTERVALS = NUM_INTERVALS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	bsgm_stream_if.sink in_ch,
	bsgm_stream_if.source out_ch
);
	bsgm_cfg_t cfg;
	logic [BOUND_REGS-1:0][63:0] lower, upper;
	logic [63:0] repl_single_q;
	bsgm_in_t in_s1;
	logic vld_s1, vld_s2;
	bsgm_out_t out_s2;
	logic adv_s2, rdy_s1;
	logic bad;
	logic [63:0] value;
	logic gap, start;
	logic [31:0] run_q, limit;
	logic prev_gap_q;

	bsgm_cfg_regs u_regs (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg), .lower(lower), .upper(upper)
	);

	always_ff @(posedge clk) begin
		repl_single_q <= {32'd0, d2f(cfg.repl)};
	end

	bsgm_classify #(.NUM_INTERVALS(NUM_INTERVALS)) u_cls (
		.cfg(cfg), .lower(lower), .upper(upper), .repl_single(repl_single_q),
		.sample_bits(in_s1.sample_bits), .bad(bad), .value(value)
	);

	assign adv_s2 = !vld_s2 || out_ch.ready;
	assign rdy_s1 = !vld_s1 || adv_s2;
	assign in_ch.ready = rdy_s1;
	assign out_ch.valid = vld_s2;
	assign out_ch.payload = out_s2;

	always_comb begin
		limit = (cfg.max_run == 32'd0) ? 32'd1 : cfg.max_run;
		gap = (in_s1.buffer_gap && !cfg.mode[1]) || (cfg.mode[0] && bad);
		start = in_s1.buffer_first || gap != prev_gap_q || run_q >= limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			run_q <= '0;
			prev_gap_q <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_ch.valid;
			if (adv_s2) begin
				vld_s2 <= vld_s1;
				if (vld_s1) begin
					prev_gap_q <= gap;
					if (start) run_q <= 32'd1;
					else if (run_q != '1) run_q <= run_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) in_s1 <= in_ch.payload;
		if (adv_s2 && vld_s1) begin
			out_s2.out_sample <= value;
			out_s2.gap_flag <= gap;
			out_s2.segment_start <= start;
			out_s2.discont_flag <= in_s1.buffer_first && in_s1.buffer_discont;
		end
	end
endmodule
`default_nettype wire

[tb/sv/tb_bad_sample_gap_marker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bad_sample_gap_marker
// Self-checking bench for the bad-sample gap marker. Configuration phases
// are written while the block is idle. A queue-fed driver sends sample
// requests, and a bit-accurate predictor computes the expected output for
// each accepted request. The monitor checks every output field against the
// oldest prediction. Both channel sides stall at random, and one long
// receiver stall makes the block back up.
// ----------------------------------------------------------------------------
module tb_bad_sample_gap_marker;
	import bsgm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsgm_stream_if #(.T(bsgm_in_t)) in_if ();
	bsgm_stream_if #(.T(bsgm_out_t)) out_if ();

	bad_sample_gap_marker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_if.sink),
		.out_ch(out_if.source)
	);

	bsgm_in_t pending_samples[$];
	bsgm_out_t expected_outputs[$];
	int errors;
	int accepted_count;
	int cycles;
	bit quiet;

	// Shadow of the block's registers and state.
	logic [5:0] mode_r;
	logic [63:0] repl_r;
	logic [1:0] icnt_r;
	logic [31:0] maxrun_r;
	logic [63:0] lower_r[2];
	logic [63:0] upper_r[2];
	logic [31:0] run_len;
	logic prev_gap;

	// Stimulus helpers for the current phase.
	logic [31:0] flo[2], fhi[2];
	logic buf_gap, buf_disc;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] widen_single(logic [31:0] f);
		int p;
		logic [63:0] fr;
		if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
		if (f[30:23] != 8'd0) return {f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0};
		if (f[22:0] == 23'd0) return {f[31], 63'd0};
		p = 0;
		for (int i = 0; i < 23; i++) if (f[i]) p = i;
		fr = 64'(f[22:0]) << (52 - p);
		return {f[31], 11'(p + 874), fr[51:0]};
	endfunction

	function automatic logic [31:0] round_to_single(logic [63:0] b);
		logic s;
		logic [62:0] mag;
		logic [63:0] sig, q;
		logic g, st;
		int fe, sh;
		s = b[63];
		mag = b[62:0];
		if (mag > 63'h7FF0000000000000) return {s, 8'hFF, 1'b1, mag[50:29]};
		if (mag >= 63'h47EFFFFFF0000000) return {s, 8'hFF, 23'd0};
		if (mag[62:52] == 11'd0) return {s, 31'd0};
		fe = int'(mag[62:52]) - 896;
		sig = {11'd0, 1'b1, mag[51:0]};
		if (fe >= 1) begin
			q = (64'(fe) << 23) | 64'(mag[51:29]);
			g = mag[28];
			st = |mag[27:0];
		end else begin
			sh = 30 - fe;
			if (sh > 60) sh = 60;
			q = sig >> sh;
			g = sig[sh-1];
			st = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
		end
		if (g && (st || q[0])) q = q + 64'd1;
		return {s, q[30:0]};
	endfunction

	function automatic bit is_nan(logic [63:0] d);
		return d[62:52] == 11'h7FF && d[51:0] != 52'd0;
	endfunction

	function automatic bit le_double(logic [63:0] a, logic [63:0] b);
		if (is_nan(a) || is_nan(b)) return 1'b0;
		if (a[62:0] == 63'd0 && b[62:0] == 63'd0) return 1'b1;
		if (a[63] != b[63]) return a[63];
		if (!a[63]) return a[62:0] <= b[62:0];
		return a[62:0] >= b[62:0];
	endfunction

	function bsgm_out_t mark_sample(bsgm_in_t it);
		bsgm_out_t r;
		logic [63:0] sb, x;
		bit bad, gap, start;
		int n;
		logic [31:0] lim;
		sb = mode_r[5] ? {32'd0, it.sample_bits[31:0]} : it.sample_bits;
		x = mode_r[5] ? widen_single(sb[31:0]) : sb;
		n = (icnt_r > 2) ? 2 : icnt_r;
		bad = 1'b0;
		for (int i = 0; i < n; i++)
			if (le_double(lower_r[i], x) && le_double(x, upper_r[i])) bad = 1'b1;
		if (mode_r[2] && is_nan(x)) bad = 1'b1;
		if (mode_r[3] && x[62:0] == 63'h7FF0000000000000) bad = 1'b1;
		gap = (it.buffer_gap && !mode_r[1]) || (mode_r[0] && bad);
		lim = (maxrun_r == 32'd0) ? 32'd1 : maxrun_r;
		start = it.buffer_first || gap != prev_gap || run_len >= lim;
		if (bad && mode_r[4])
			r.out_sample = mode_r[5] ? {32'd0, round_to_single(repl_r)} : repl_r;
		else
			r.out_sample = sb;
		if (start) run_len = 32'd1;
		else if (run_len != 32'hFFFFFFFF) run_len = run_len + 32'd1;
		prev_gap = gap;
		r.gap_flag = gap;
		r.segment_start = start;
		r.discont_flag = it.buffer_first && it.buffer_discont;
		return r;
	endfunction

	// Predict at acceptance, in the configuration in force at that edge.
	always @(posedge clk) begin
		if (arst_n && in_if.valid && in_if.ready) begin
			expected_outputs.push_back(mark_sample(in_if.payload));
			accepted_count++;
		end
	end

	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.payload <= '0;
			send_gap = 0;
		end else if (!in_if.valid || in_if.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_if.valid <= 1'b0;
			end else if (!quiet && pending_samples.size() != 0 &&
					$urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(1, 13) - 1;
				in_if.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				in_if.payload <= pending_samples.pop_front();
				in_if.valid <= 1'b1;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	int stall_left, hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			hold_done = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else if (!hold_done && accepted_count >= 300) begin
			hold_done = 1;
			hold_left = 400;
			out_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_if.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bsgm_out_t e, a;
		if (arst_n && out_if.valid && out_if.ready) begin
			a = out_if.payload;
			if (expected_outputs.size() == 0) begin
				$display("%0t unexpected output: expected none, actual %h", $time, a);
				errors++;
			end else begin
				e = expected_outputs.pop_front();
				if (e.out_sample !== a.out_sample) begin
					$display("%0t out_sample: expected %h, actual %h", $time,
						e.out_sample, a.out_sample);
					errors++;
				end
				if (e.gap_flag !== a.gap_flag) begin
					$display("%0t gap_flag: expected %b, actual %b", $time,
						e.gap_flag, a.gap_flag);
					errors++;
				end
				if (e.segment_start !== a.segment_start) begin
					$display("%0t segment_start: expected %b, actual %b", $time,
						e.segment_start, a.segment_start);
					errors++;
				end
				if (e.discont_flag !== a.discont_flag) begin
					$display("%0t discont_flag: expected %b, actual %b", $time,
						e.discont_flag, a.discont_flag);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bad_sample_gap_marker NOT OK");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE: mode_r = val[5:0];
			REG_REPL: repl_r = val;
			REG_ICNT: icnt_r = val[1:0];
			REG_MAXRUN: maxrun_r = val[31:0];
			REG_LOWER0: lower_r[0] = val;
			REG_UPPER0: upper_r[0] = val;
			REG_LOWER1: lower_r[1] = val;
			REG_UPPER1: upper_r[1] = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || expected_outputs.size() != 0 || in_if.valid)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_replacement();
		case ($urandom_range(0, 7))
			0: return 64'h47EFFFFFF0000000;
			1: return 64'hC7EFFFFFE8000000;
			2: return 64'h7FF8000000000001 | (rand64() & 64'h8007FFFFFFFFFFFF);
			3: return {1'b0, 11'(874 + $urandom_range(0, 30)), rand64() & 64'hFFFFFFFFFFFFF};
			4: return 64'h7FF0000000000000;
			5: return 64'h3FF0000010000000;
			default: return rand64();
		endcase
	endfunction

	// Bound pair in single precision; the sign is shared so bit order is order.
	task automatic make_bounds(int i, bit single_mode);
		logic [31:0] a;
		logic [63:0] d;
		a = {$urandom_range(0, 1) == 1, 8'($urandom_range(8'h70, 8'h90)), 23'($urandom)};
		flo[i] = a;
		fhi[i] = a + $urandom_range(0, 1 << 20);
		if (a[31]) begin
			flo[i] = fhi[i];
			fhi[i] = a;
		end
		if ($urandom_range(0, 9) == 0) flo[i] = 32'h7FC00000;
		if ($urandom_range(0, 9) == 0) begin
			a = flo[i];
			flo[i] = fhi[i];
			fhi[i] = a;
		end
		if (single_mode) begin
			d = widen_single(flo[i]);
			write_reg(i ? REG_LOWER1 : REG_LOWER0, d);
			write_reg(i ? REG_UPPER1 : REG_UPPER0, widen_single(fhi[i]));
		end else begin
			d = rand64();
			write_reg(i ? REG_LOWER1 : REG_LOWER0, widen_single(flo[i]) | 64'(d[28:0]));
			write_reg(i ? REG_UPPER1 : REG_UPPER0, widen_single(fhi[i]) | 64'(d[57:29]));
		end
	endtask

	function automatic logic [31:0] gen_single();
		logic [31:0] r, lo, hi;
		int i;
		i = $urandom_range(0, 1);
		lo = flo[i][31] ? fhi[i] : flo[i];
		hi = flo[i][31] ? flo[i] : fhi[i];
		case ($urandom_range(0, 9))
			0, 1: r = (hi >= lo) ? lo + ($urandom % (hi - lo + 1)) : lo;
			2: r = $urandom_range(0, 1) ? flo[i] : fhi[i];
			3: r = flo[i] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
			4: r = {$urandom_range(0, 1) == 1, 31'h7F800000};
			5: r = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom) | 23'd1};
			6: r = {$urandom_range(0, 1) == 1, 31'd0};
			7: r = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
			default: r = $urandom;
		endcase
		return r;
	endfunction

	function automatic bsgm_in_t gen_item();
		bsgm_in_t it;
		logic [63:0] s;
		it.buffer_first = $urandom_range(0, 7) == 0;
		if (it.buffer_first) begin
			buf_gap = $urandom_range(0, 3) == 0;
			buf_disc = $urandom_range(0, 2) == 0;
		end
		it.buffer_gap = buf_gap;
		it.buffer_discont = buf_disc ^ ($urandom_range(0, 15) == 0);
		if (mode_r[5]) begin
			s = {$urandom, gen_single()};
		end else begin
			case ($urandom_range(0, 6))
				0: s = rand64();
				1: s = {$urandom_range(0, 1) == 1, 63'h7FF0000000000000};
				2: s = {$urandom_range(0, 1) == 1, 11'h7FF, 52'(rand64()) | 52'd1};
				3: s = lower_r[$urandom_range(0, 1)];
				4: s = upper_r[$urandom_range(0, 1)] + ($urandom_range(0, 1) ? 64'd1 : -64'd1);
				default: s = widen_single(gen_single()) | 64'($urandom_range(0, 1 << 28));
			endcase
		end
		it.sample_bits = s;
		return it;
	endfunction

	task automatic push_sample(logic [63:0] s, bit g, bit d, bit f);
		bsgm_in_t it;
		it.sample_bits = s;
		it.buffer_gap = g;
		it.buffer_discont = d;
		it.buffer_first = f;
		pending_samples.push_back(it);
	endtask

	initial begin
		logic [5:0] m;
		logic [31:0] mr;
		errors = 0;
		accepted_count = 0;
		cycles = 0;
		quiet = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		buf_gap = 0;
		buf_disc = 0;
		mode_r = MODE_RESET;
		repl_r = '0;
		icnt_r = '0;
		maxrun_r = 32'hFFFFFFFF;
		lower_r = '{64'd0, 64'd0};
		upper_r = '{64'd0, 64'd0};
		flo = '{32'd0, 32'd0};
		fhi = '{32'd0, 32'd0};
		run_len = '0;
		prev_gap = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: a gap without a buffer start, then the special values.
		push_sample(64'h3FF0000000000000, 1, 1, 0);
		push_sample(64'h0000000000000000, 1, 0, 0);
		push_sample(64'h0000000000000000, 0, 0, 0);
		push_sample(64'h7FF0000000000000, 0, 1, 1);
		push_sample(64'hFFF0000000000000, 0, 0, 0);
		push_sample(64'h7FF8000000000000, 0, 0, 0);
		push_sample(64'hFFFFFFFFFFFFFFFF, 1, 1, 1);
		push_sample(64'h8000000000000000, 0, 0, 0);
		push_sample(64'h7FEFFFFFFFFFFFFF, 0, 0, 0);
		push_sample(64'h0000000000000001, 0, 0, 1);
		wait_idle();

		// Extremes, then random settings.
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: m = 6'h3F;
				1: m = 6'h00;
				2: m = 6'h1D;
				3: m = 6'h3D;
				default: m = 6'($urandom);
			endcase
			case (p % 5)
				0: mr = 32'd0;
				1: mr = 32'd1;
				2: mr = 32'hFFFFFFFF;
				3: mr = 32'hFFFFFFFE;
				default: mr = $urandom_range(2, 9);
			endcase
			if (p == 9) quiet = 1;
			write_reg(REG_MODE, {$urandom, $urandom_range(0, 3) << 6 | m});
			write_reg(REG_REPL, p == 1 ? 64'hFFFFFFFFFFFFFFFF : pick_replacement());
			write_reg(REG_ICNT, (rand64() & ~64'd3) | 64'(p % 4));
			write_reg(REG_MAXRUN, {$urandom, mr});
			make_bounds(0, m[5]);
			make_bounds(1, m[5]);
			if (p == 0) begin
				// Single-precision samples: one, a NaN payload, an infinity, the bounds, a subnormal and -0.
				push_sample(64'h3F800000, 0, 0, 1);
				push_sample(64'h7F800001, 0, 0, 0);
				push_sample(64'hFFFFFFFF7F800000, 0, 0, 0);
				push_sample({32'h0, flo[0]}, 1, 0, 0);
				push_sample({32'h0, fhi[1]}, 0, 0, 0);
				push_sample(64'h00000001, 0, 1, 1);
				push_sample(64'h80000000, 1, 1, 0);
			end
			for (int k = 0; k < 190; k++) pending_samples.push_back(gen_item());
			wait_idle();
		end

		if (errors == 0)
			$display("tb_bad_sample_gap_marker OK");
		else
			$display("tb_bad_sample_gap_marker NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

[bad_sample_gap_marker.f]
rtl/core/bsgm_pkg.sv
rtl/core/bsgm_stream_if.sv
rtl/core/bsgm_cfg_regs.sv
rtl/core/bsgm_classify.sv
rtl/core/bad_sample_gap_marker.sv
tb/sv/tb_bad_sample_gap_marker.sv
